### rtl/pwb_pkg.sv
// ----------------------------------------------------------------------------
// pwb_pkg: shared types and constants of the perspective warp engine
// Holds the fixed datapath widths, the item kinds and the pipeline item type.
// ----------------------------------------------------------------------------
package pwb_pkg;

  // Fixed field widths.
  localparam int unsigned CoordW  = 12;
  localparam int unsigned CoefW   = 32;
  localparam int unsigned NumCoef = 8;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixW    = 3 * ChanW;

  // Datapath widths: transform products, sums, divider and blend.
  localparam int unsigned ProdW   = 46;
  localparam int unsigned SumW    = 48;
  localparam int unsigned DivW    = 49;
  localparam int unsigned QuotW   = 28;
  localparam int unsigned FracW   = 16;
  localparam int unsigned WeightW = 33;
  localparam int unsigned BlendW  = WeightW + ChanW;
  localparam int unsigned AccW    = BlendW + 1;

  // Default geometry.
  localparam int unsigned DefSrcW    = 512;
  localparam int unsigned DefSrcH    = 512;
  localparam int unsigned DefOutWMax = 4096;
  localparam int unsigned DefOutHMax = 4096;

  // Item kinds carried in tuser.
  localparam logic KindLoad    = 1'b0;
  localparam logic KindRequest = 1'b1;

  // The constant 1 of the projective row, in 30 fraction bits.
  localparam logic signed [SumW-1:0] DenOne = SumW'(64'd1 << 30);

  // Rounding offset of the blend sum: one half in 32 fraction bits.
  localparam logic [AccW-1:0] RoundHalf = AccW'(64'd1 << 31);

  // One in the 16-bit fraction format of the bilinear weights.
  localparam logic [FracW:0] WeightOne = (FracW+1)'(1 << FracW);

  typedef logic [NumCoef-1:0][CoefW-1:0] coef_bank_t;

  // Reset values: identity matrix.
  localparam coef_bank_t CoefReset = {32'd0, 32'd0, 32'd0, 32'd65536,
                                      32'd0, 32'd0, 32'd0, 32'd65536};

  // One item as it travels down the pipeline.
  typedef struct packed {
    logic              kind;
    logic              keep;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [PixW-1:0]   rgb;
  } item_t;

  // Parity bits of the 2x2 neighborhood, used to pick the four image banks.
  typedef struct packed {
    logic ix0;
    logic nx0;
    logic iy0;
    logic ny0;
  } nbr_sel_t;

endpackage

### rtl/pwb_transform.sv
// ----------------------------------------------------------------------------
// pwb_transform: homography numerators and denominator
// Two stages: six 32x14 products, then the three sums X, Y and D.
// ----------------------------------------------------------------------------
module pwb_transform (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             valid_i,
  input  pwb_pkg::item_t                   item_i,
  input  pwb_pkg::coef_bank_t              coef_i,
  output logic                             valid_o,
  output pwb_pkg::item_t                   item_o,
  output logic signed [pwb_pkg::SumW-1:0]  x_num_o,
  output logic signed [pwb_pkg::SumW-1:0]  y_num_o,
  output logic signed [pwb_pkg::SumW-1:0]  den_o
);

  logic [pwb_pkg::CoordW:0]               u1, v1;
  logic signed [pwb_pkg::ProdW-1:0]       prod_q [6];
  logic                                   p_valid_q;
  pwb_pkg::item_t                         p_item_q;
  logic                                   s_valid_q;
  pwb_pkg::item_t                         s_item_q;
  logic signed [pwb_pkg::SumW-1:0]        x_q, y_q, d_q;

  // Homogeneous coordinates start at one.
  assign u1 = {1'b0, item_i.px} + (pwb_pkg::CoordW+1)'(1);
  assign v1 = {1'b0, item_i.py} + (pwb_pkg::CoordW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (adv_i) begin
      p_valid_q <= valid_i;
      s_valid_q <= p_valid_q;
    end
  end

  // Product stage, then the sum stage.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_item_q  <= item_i;
      prod_q[0] <= $signed(coef_i[0]) * $signed({1'b0, u1});
      prod_q[1] <= $signed(coef_i[1]) * $signed({1'b0, v1});
      prod_q[2] <= $signed(coef_i[3]) * $signed({1'b0, u1});
      prod_q[3] <= $signed(coef_i[4]) * $signed({1'b0, v1});
      prod_q[4] <= $signed(coef_i[6]) * $signed({1'b0, u1});
      prod_q[5] <= $signed(coef_i[7]) * $signed({1'b0, v1});
      s_item_q  <= p_item_q;
      x_q <= pwb_pkg::SumW'(prod_q[0]) + pwb_pkg::SumW'(prod_q[1]) +
             pwb_pkg::SumW'($signed(coef_i[2]));
      y_q <= pwb_pkg::SumW'(prod_q[2]) + pwb_pkg::SumW'(prod_q[3]) +
             pwb_pkg::SumW'($signed(coef_i[5]));
      d_q <= pwb_pkg::SumW'(prod_q[4]) + pwb_pkg::SumW'(prod_q[5]) + pwb_pkg::DenOne;
    end
  end

  assign valid_o = s_valid_q;
  assign item_o  = s_item_q;
  assign x_num_o = x_q;
  assign y_num_o = y_q;
  assign den_o   = d_q;

endmodule

### rtl/pwb_div.sv
// ----------------------------------------------------------------------------
// pwb_div: pipelined restoring divider for both sample coordinates
// One quotient bit per stage and lane; gives floor(num * 2^30 / den) in
// 28 bits, with flags for a non-positive numerator and for saturation.
// ----------------------------------------------------------------------------
module pwb_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   adv_i,
  input  logic                                   valid_i,
  input  pwb_pkg::item_t                         item_i,
  input  logic signed [pwb_pkg::SumW-1:0]        x_num_i,
  input  logic signed [pwb_pkg::SumW-1:0]        y_num_i,
  input  logic signed [pwb_pkg::SumW-1:0]        den_i,
  output logic                                   valid_o,
  output pwb_pkg::item_t                         item_o,
  output logic                                   bad_o,
  output logic [1:0]                             zero_o,
  output logic [1:0]                             sat_o,
  output logic [1:0][pwb_pkg::QuotW-1:0]         quo_o
);

  localparam int unsigned NStage = pwb_pkg::QuotW;

  logic signed [pwb_pkg::SumW-1:0] num [2];
  logic [pwb_pkg::DivW-1:0]        num_sh [2];
  logic [pwb_pkg::DivW-1:0]        den_ext;
  logic [1:0]                      pos, sat;
  logic                            bad;

  logic [NStage:0]                 vld_q;
  pwb_pkg::item_t                  item_q [NStage+1];
  logic [NStage:0]                 bad_q;
  logic [pwb_pkg::DivW-1:0]        den_q  [NStage+1];
  logic [pwb_pkg::DivW-1:0]        rem_q  [NStage+1][2];
  logic [pwb_pkg::QuotW-1:0]       quo_q  [NStage+1][2];
  logic [1:0]                      zero_q [NStage+1];
  logic [1:0]                      sat_q  [NStage+1];

  logic [pwb_pkg::DivW-1:0]        rem_d  [1:NStage][2];
  logic [pwb_pkg::QuotW-1:0]       quo_d  [1:NStage][2];

  assign num[0] = x_num_i;
  assign num[1] = y_num_i;

  // Entry checks: sign of D, sign of each numerator, and quotient range.
  always_comb begin
    bad     = den_i[pwb_pkg::SumW-1] || (den_i == '0);
    den_ext = pwb_pkg::DivW'(den_i[pwb_pkg::SumW-2:0]);
    for (int l = 0; l < 2; l++) begin
      pos[l]    = !num[l][pwb_pkg::SumW-1] && (num[l] != '0);
      num_sh[l] = {num[l][pwb_pkg::SumW-2:0], 2'b00};
      sat[l]    = num_sh[l] >= den_ext;
    end
  end

  // One shift, compare and subtract per stage and lane.
  always_comb begin
    for (int k = 1; k <= NStage; k++) begin
      for (int l = 0; l < 2; l++) begin
        rem_d[k][l] = {rem_q[k-1][l][pwb_pkg::DivW-2:0], 1'b0};
        if (rem_d[k][l] >= den_q[k-1]) begin
          rem_d[k][l] = rem_d[k][l] - den_q[k-1];
          quo_d[k][l] = {quo_q[k-1][l][pwb_pkg::QuotW-2:0], 1'b1};
        end else begin
          quo_d[k][l] = {quo_q[k-1][l][pwb_pkg::QuotW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NStage-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q[0] <= item_i;
      bad_q[0]  <= bad;
      den_q[0]  <= den_ext;
      zero_q[0] <= ~pos;
      sat_q[0]  <= sat;
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l] <= num_sh[l];
        quo_q[0][l] <= '0;
      end
      for (int k = 1; k <= NStage; k++) begin
        item_q[k] <= item_q[k-1];
        bad_q[k]  <= bad_q[k-1];
        den_q[k]  <= den_q[k-1];
        zero_q[k] <= zero_q[k-1];
        sat_q[k]  <= sat_q[k-1];
        for (int l = 0; l < 2; l++) begin
          rem_q[k][l] <= rem_d[k][l];
          quo_q[k][l] <= quo_d[k][l];
        end
      end
    end
  end

  assign valid_o  = vld_q[NStage];
  assign item_o   = item_q[NStage];
  assign bad_o    = bad_q[NStage];
  assign zero_o   = zero_q[NStage];
  assign sat_o    = sat_q[NStage];
  assign quo_o[0] = quo_q[NStage][0];
  assign quo_o[1] = quo_q[NStage][1];

endmodule

### rtl/pwb_mem.sv
// ----------------------------------------------------------------------------
// pwb_mem: source image store in four parity banks
// Bank {row parity, column parity} holds every other pixel, so a 2x2
// neighborhood reads each bank once. A sweep clears all banks after reset.
// ----------------------------------------------------------------------------
module pwb_mem #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AddrW = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            wr_en_i,
  input  logic [1:0]                      wr_bank_i,
  input  logic [pwb_pkg::PixW-1:0]        wr_data_i,
  input  logic [3:0][AddrW-1:0]           addr_i,
  output logic [3:0][pwb_pkg::PixW-1:0]   rdata_o,
  output logic                            busy_o
);

  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  // Clearing sweep, one entry of every bank per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + AddrW'(1);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [pwb_pkg::PixW-1:0] mem [Depth];
    logic [pwb_pkg::PixW-1:0] rdata_q;

    // One write and one registered read per cycle while the pipeline advances and no sweep runs.
    always_ff @(posedge clk_i) begin
      if (clr_busy_q) begin
        mem[clr_addr_q] <= '0;
      end else if (adv_i) begin
        if (wr_en_i && (wr_bank_i == 2'(b))) begin
          mem[addr_i[b]] <= wr_data_i;
        end
        rdata_q <= mem[addr_i[b]];
      end
    end

    assign rdata_o[b] = rdata_q;
  end

  assign busy_o = clr_busy_q;

endmodule

### rtl/pwb_blend.sv
// ----------------------------------------------------------------------------
// pwb_blend: bilinear weights and channel blend
// Stage one forms the four Q32 weights while the banks are read; stage two
// multiplies them by the selected pixels; the rounded sum leaves as logic.
// ----------------------------------------------------------------------------
module pwb_blend (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 valid_i,
  input  pwb_pkg::item_t                       item_i,
  input  logic                                 bad_i,
  input  logic [pwb_pkg::FracW-1:0]            fx_i,
  input  logic [pwb_pkg::FracW-1:0]            fy_i,
  input  pwb_pkg::nbr_sel_t                    sel_i,
  input  logic [3:0][pwb_pkg::PixW-1:0]        rdata_i,
  output logic                                 valid_o,
  output pwb_pkg::item_t                       item_o,
  output logic                                 bad_o,
  output logic [2:0][pwb_pkg::ChanW-1:0]       chan_o
);

  logic [pwb_pkg::FracW:0]     omx, omy, fxe, fye;
  logic                        w_valid_q, p_valid_q;
  pwb_pkg::item_t              w_item_q, p_item_q;
  logic                        w_bad_q, p_bad_q;
  pwb_pkg::nbr_sel_t           w_sel_q;
  logic [pwb_pkg::WeightW-1:0] w_q [4];
  logic [pwb_pkg::PixW-1:0]    pix [4];
  logic [pwb_pkg::BlendW-1:0]  prod_q [4][3];
  logic [pwb_pkg::AccW-1:0]    acc [3];
  logic [pwb_pkg::AccW-pwb_pkg::WeightW:0] whole [3];

  assign omx = pwb_pkg::WeightOne - {1'b0, fx_i};
  assign omy = pwb_pkg::WeightOne - {1'b0, fy_i};
  assign fxe = {1'b0, fx_i};
  assign fye = {1'b0, fy_i};

  // Neighbors in order top-left, top-right, bottom-left, bottom-right.
  assign pix[0] = rdata_i[{w_sel_q.iy0, w_sel_q.ix0}];
  assign pix[1] = rdata_i[{w_sel_q.iy0, w_sel_q.nx0}];
  assign pix[2] = rdata_i[{w_sel_q.ny0, w_sel_q.ix0}];
  assign pix[3] = rdata_i[{w_sel_q.ny0, w_sel_q.nx0}];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
    end else if (adv_i) begin
      w_valid_q <= valid_i;
      p_valid_q <= w_valid_q;
    end
  end

  // Weight stage, then the product stage.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      w_item_q <= item_i;
      w_bad_q  <= bad_i;
      w_sel_q  <= sel_i;
      w_q[0]   <= pwb_pkg::WeightW'(omx * omy);
      w_q[1]   <= pwb_pkg::WeightW'(fxe * omy);
      w_q[2]   <= pwb_pkg::WeightW'(omx * fye);
      w_q[3]   <= pwb_pkg::WeightW'(fxe * fye);
      p_item_q <= w_item_q;
      p_bad_q  <= w_bad_q;
      for (int n = 0; n < 4; n++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[n][c] <= pwb_pkg::BlendW'(w_q[n]) *
                          pwb_pkg::BlendW'(pix[n][pwb_pkg::ChanW*(2-c) +: pwb_pkg::ChanW]);
        end
      end
    end
  end

  // Round half up and saturate each channel.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = pwb_pkg::AccW'(prod_q[0][c]) + pwb_pkg::AccW'(prod_q[1][c]) +
               pwb_pkg::AccW'(prod_q[2][c]) + pwb_pkg::AccW'(prod_q[3][c]) +
               pwb_pkg::RoundHalf;
      whole[c] = acc[c][pwb_pkg::AccW-1:pwb_pkg::WeightW-1];
      chan_o[c] = (whole[c] > (pwb_pkg::AccW-pwb_pkg::WeightW+1)'(255)) ?
                  pwb_pkg::ChanW'(255) : whole[c][pwb_pkg::ChanW-1:0];
    end
  end

  assign valid_o = p_valid_q;
  assign item_o  = p_item_q;
  assign bad_o   = p_bad_q;

endmodule

### rtl/perspective_warp_bilinear.sv
// A request's result passes the transform, divider, sample, blend and output
// registers; the engine takes one item per cycle unless output or sweep stalls.
// Loads travel the same pipeline and write the image banks at the read stage.
// Reset clears the coefficients to identity and sweeps the image banks to
// zero, ceil(SRC_W/2)*ceil(SRC_H/2) entries each (65536 by default), with
// s_axis_tready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// perspective_warp_bilinear: homography inverse warp with bilinear sampling
// Load items fill the source image; request items map an output pixel
// through the matrix and blend the 2x2 source neighborhood.
// ----------------------------------------------------------------------------
module perspective_warp_bilinear #(
  parameter int unsigned SRC_W     = pwb_pkg::DefSrcW,
  parameter int unsigned SRC_H     = pwb_pkg::DefSrcH,
  parameter int unsigned OUT_W_MAX = pwb_pkg::DefOutWMax,
  parameter int unsigned OUT_H_MAX = pwb_pkg::DefOutHMax
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[11:0], pos_y[23:12], in_red[31:24], in_green[39:32], in_blue[47:40]
  input  logic [47:0] s_axis_tdata,
  // kind[0]
  input  logic [0:0]  s_axis_tuser,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_u[11:0], out_v[23:12], out_red[31:24], out_green[39:32], out_blue[47:40]
  output logic [47:0] m_axis_tdata,
  // bad_denominator[0]
  output logic [0:0]  m_axis_tuser,
  // Coefficient writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned CW       = pwb_pkg::CoordW;
  localparam int unsigned HalfW    = (SRC_W + 1) / 2;
  localparam int unsigned HalfH    = (SRC_H + 1) / 2;
  localparam int unsigned BankDep  = HalfW * HalfH;
  localparam int unsigned AddrW    = (BankDep > 1) ? $clog2(BankDep) : 1;
  localparam logic [CW-1:0] LimX   = CW'(SRC_W - 1);
  localparam logic [CW-1:0] LimY   = CW'(SRC_H - 1);
  localparam logic [2*CW-1:0] HalfWV = (2*CW)'(HalfW);

  pwb_pkg::coef_bank_t coef_q;
  logic                adv, in_acc, busy, last_res;
  pwb_pkg::item_t      in_item;

  logic                          t_valid;
  pwb_pkg::item_t                t_item;
  logic signed [pwb_pkg::SumW-1:0] t_x, t_y, t_d;

  logic                          d_valid, d_bad;
  pwb_pkg::item_t                d_item;
  logic [1:0]                    d_zero, d_sat;
  logic [1:0][pwb_pkg::QuotW-1:0] d_quo;

  logic [CW-1:0]                 ip [2];
  logic [pwb_pkg::FracW-1:0]     fp [2];
  logic [CW-1:0]                 ix, iy, nx, ny, cc, rr;
  logic [3:0][AddrW-1:0]         addr_d;

  logic                          sc_valid_q, sc_bad_q;
  pwb_pkg::item_t                sc_item_q;
  logic [pwb_pkg::FracW-1:0]     sc_fx_q, sc_fy_q;
  pwb_pkg::nbr_sel_t             sc_sel_q;
  logic [3:0][AddrW-1:0]         sc_addr_q;
  logic [1:0]                    sc_bank_q;
  logic                          wr_en;

  logic [3:0][pwb_pkg::PixW-1:0] rdata;
  logic                          b_valid, b_bad;
  pwb_pkg::item_t                b_item;
  logic [2:0][pwb_pkg::ChanW-1:0] b_chan;

  logic                          out_valid_q, out_bad_q;
  logic [CW-1:0]                 out_u_q, out_v_q;
  logic [2:0][pwb_pkg::ChanW-1:0] out_chan_q;

  // Coefficient registers; the port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= pwb_pkg::CoefReset;
    end else if (cfg_valid_i) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // The pipeline moves unless a result is stuck behind a full output register.
  assign last_res      = b_valid && (b_item.kind == pwb_pkg::KindRequest) && b_item.keep;
  assign adv           = !last_res || !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv && !busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Unpack the input item and decide whether it has any effect.
  always_comb begin
    in_item.kind = s_axis_tuser[0];
    in_item.px   = s_axis_tdata[11:0];
    in_item.py   = s_axis_tdata[23:12];
    in_item.rgb  = {s_axis_tdata[31:24], s_axis_tdata[39:32], s_axis_tdata[47:40]};
    if (in_item.kind == pwb_pkg::KindLoad) begin
      in_item.keep = ({1'b0, in_item.px} < (CW+1)'(SRC_W)) &&
                     ({1'b0, in_item.py} < (CW+1)'(SRC_H));
    end else begin
      in_item.keep = ({1'b0, in_item.px} < (CW+1)'(OUT_W_MAX)) &&
                     ({1'b0, in_item.py} < (CW+1)'(OUT_H_MAX));
    end
  end

  pwb_transform u_transform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_acc),
    .item_i  (in_item),
    .coef_i  (coef_q),
    .valid_o (t_valid),
    .item_o  (t_item),
    .x_num_o (t_x),
    .y_num_o (t_y),
    .den_o   (t_d)
  );

  pwb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (t_valid),
    .item_i  (t_item),
    .x_num_i (t_x),
    .y_num_i (t_y),
    .den_i   (t_d),
    .valid_o (d_valid),
    .item_o  (d_item),
    .bad_o   (d_bad),
    .zero_o  (d_zero),
    .sat_o   (d_sat),
    .quo_o   (d_quo)
  );

  // Clamp the sample position to the image and split integer and fraction.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (d_zero[l]) begin
        ip[l] = '0;
        fp[l] = '0;
      end else if (d_sat[l] ||
                   d_quo[l][pwb_pkg::QuotW-1:pwb_pkg::FracW] >= ((l == 0) ? LimX : LimY)) begin
        ip[l] = (l == 0) ? LimX : LimY;
        fp[l] = '0;
      end else begin
        ip[l] = d_quo[l][pwb_pkg::QuotW-1:pwb_pkg::FracW];
        fp[l] = d_quo[l][pwb_pkg::FracW-1:0];
      end
    end
    // A load addresses its own pixel through the same path.
    if (d_item.kind == pwb_pkg::KindLoad) begin
      ix = d_item.px;
      iy = d_item.py;
    end else begin
      ix = ip[0];
      iy = ip[1];
    end
    nx = (ix == LimX) ? ix : ix + CW'(1);
    ny = (iy == LimY) ? iy : iy + CW'(1);
    // Each bank takes whichever neighbor column and row have its parity.
    for (int b = 0; b < 4; b++) begin
      cc = (ix[0] == b[0]) ? ix : nx;
      rr = (iy[0] == b[1]) ? iy : ny;
      addr_d[b] = AddrW'(((2*CW)'(rr >> 1)) * HalfWV + (2*CW)'(cc >> 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_valid_q <= 1'b0;
    end else if (adv) begin
      sc_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_item_q <= d_item;
      sc_bad_q  <= d_bad;
      sc_fx_q   <= fp[0];
      sc_fy_q   <= fp[1];
      sc_sel_q  <= '{ix0: ix[0], nx0: nx[0], iy0: iy[0], ny0: ny[0]};
      sc_addr_q <= addr_d;
      sc_bank_q <= {iy[0], ix[0]};
    end
  end

  assign wr_en = sc_valid_q && (sc_item_q.kind == pwb_pkg::KindLoad) && sc_item_q.keep;

  pwb_mem #(
    .Depth (BankDep),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .wr_en_i   (wr_en),
    .wr_bank_i (sc_bank_q),
    .wr_data_i (sc_item_q.rgb),
    .addr_i    (sc_addr_q),
    .rdata_o   (rdata),
    .busy_o    (busy)
  );

  pwb_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sc_valid_q),
    .item_i  (sc_item_q),
    .bad_i   (sc_bad_q),
    .fx_i    (sc_fx_q),
    .fy_i    (sc_fy_q),
    .sel_i   (sc_sel_q),
    .rdata_i (rdata),
    .valid_o (b_valid),
    .item_o  (b_item),
    .bad_o   (b_bad),
    .chan_o  (b_chan)
  );

  // Output register; a bad denominator forces the channels to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !m_axis_tready) || (adv && last_res);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_res) begin
      out_u_q    <= b_item.px;
      out_v_q    <= b_item.py;
      out_bad_q  <= b_bad;
      out_chan_q <= b_bad ? '0 : b_chan;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_chan_q[2], out_chan_q[1], out_chan_q[0], out_v_q, out_u_q};
  assign m_axis_tuser  = out_bad_q;

endmodule

### sim/perspective_warp_bilinear_tb.sv
// ----------------------------------------------------------------------------
// perspective_warp_bilinear_tb: self-checking bench for the warp engine
// Loads source pixels and sends warp requests under several coefficient
// sets and flow-control patterns. A scoreboard predicts each result from
// its own copy of the image and the matrix, and compares it field by field.
// ----------------------------------------------------------------------------
module perspective_warp_bilinear_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ImgW     = 512;
  localparam int unsigned ImgH     = 512;
  localparam int unsigned OutWMax  = 4096;
  localparam int unsigned OutHMax  = 4096;
  localparam int unsigned DrainGap = 40;
  localparam int unsigned CycleCap = 1000000;
  localparam int unsigned RandPerPhase = 230;

  // Coefficient register indexes.
  localparam logic [2:0] RegA0 = 3'd0;
  localparam logic [2:0] RegA1 = 3'd1;
  localparam logic [2:0] RegA2 = 3'd2;
  localparam logic [2:0] RegA3 = 3'd3;
  localparam logic [2:0] RegA4 = 3'd4;
  localparam logic [2:0] RegA5 = 3'd5;
  localparam logic [2:0] RegA6 = 3'd6;
  localparam logic [2:0] RegA7 = 3'd7;

  // Flow-control patterns of the four phases.
  typedef enum int {FlowFree, FlowSendIdle, FlowRecvStall, FlowBoth} flow_e;

  typedef struct packed {
    logic        kind;
    logic [11:0] px;
    logic [11:0] py;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_item_t;

  typedef struct packed {
    logic [11:0] u;
    logic [11:0] v;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        bad_den;
  } warp_result_t;

  // Scoreboard: mirrors the image store and the matrix, predicts results.
  class warp_scoreboard;
    logic [23:0]  image_mem [ImgW*ImgH];
    longint       coef [8];
    warp_result_t pending_pixels [$];
    int           mismatches;
    int           checked;
    int           bad_den_seen;

    function void clear();
      foreach (image_mem[i]) image_mem[i] = '0;
      foreach (coef[i]) coef[i] = 0;
      coef[0] = 65536;
      coef[4] = 65536;
      mismatches = 0;
      checked = 0;
      bad_den_seen = 0;
    endfunction

    function void set_coef(int idx, logic [31:0] value);
      coef[idx] = longint'($signed(value));
    endfunction

    // Sample coordinate: clamped integer part and Q16 fraction.
    function void sample_coord(longint num, longint den, int unsigned lim,
                               output int unsigned ip, output int unsigned fp);
      longint unsigned n, d, q, r;
      if (num <= 0) begin
        ip = 0;
        fp = 0;
        return;
      end
      n = longint'(num) << 14;
      d = den;
      q = n / d;
      r = n % d;
      if (q >= lim - 1) begin
        ip = lim - 1;
        fp = 0;
      end else begin
        ip = 32'(q);
        fp = 32'((r << 16) / d);
      end
    endfunction

    function void note_item(pixel_item_t it);
      longint u1, v1, xn, yn, den;
      int unsigned ix, fx, iy, fy, nx, ny;
      logic [23:0] p00, p10, p01, p11;
      longint unsigned w00, w10, w01, w11, s, c;
      warp_result_t res;
      if (it.kind == pwb_pkg::KindLoad) begin
        if (it.px < ImgW && it.py < ImgH)
          image_mem[it.py * ImgW + it.px] = {it.red, it.green, it.blue};
        return;
      end
      if (it.px >= OutWMax || it.py >= OutHMax) return;
      res = '0;
      res.u = it.px;
      res.v = it.py;
      u1 = longint'(it.px) + 1;
      v1 = longint'(it.py) + 1;
      den = coef[6] * u1 + coef[7] * v1 + (longint'(1) << 30);
      if (den <= 0) begin
        res.bad_den = 1'b1;
        pending_pixels.push_back(res);
        return;
      end
      xn = coef[0] * u1 + coef[1] * v1 + coef[2];
      yn = coef[3] * u1 + coef[4] * v1 + coef[5];
      sample_coord(xn, den, ImgW, ix, fx);
      sample_coord(yn, den, ImgH, iy, fy);
      nx = (ix + 1 < ImgW) ? ix + 1 : ix;
      ny = (iy + 1 < ImgH) ? iy + 1 : iy;
      p00 = image_mem[iy * ImgW + ix];
      p10 = image_mem[iy * ImgW + nx];
      p01 = image_mem[ny * ImgW + ix];
      p11 = image_mem[ny * ImgW + nx];
      w00 = longint'(65536 - fx) * (65536 - fy);
      w10 = longint'(fx) * (65536 - fy);
      w01 = longint'(65536 - fx) * fy;
      w11 = longint'(fx) * fy;
      // Blend each channel, red in the top byte.
      for (int k = 0; k < 3; k++) begin
        s = w00 * p00[16-8*k +: 8] + w10 * p10[16-8*k +: 8] +
            w01 * p01[16-8*k +: 8] + w11 * p11[16-8*k +: 8];
        c = (s + (longint'(1) << 31)) >> 32;
        if (c > 255) c = 255;
        case (k)
          0: res.red = c[7:0];
          1: res.green = c[7:0];
          default: res.blue = c[7:0];
        endcase
      end
      pending_pixels.push_back(res);
    endfunction

    function void check_result(warp_result_t got);
      warp_result_t want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result u=%0d v=%0d", got.u, got.v);
        return;
      end
      want = pending_pixels.pop_front();
      checked++;
      if (got.bad_den) bad_den_seen++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d exp u=%0d v=%0d rgb=%0d,%0d,%0d bad=%0d got u=%0d v=%0d rgb=%0d,%0d,%0d bad=%0d",
                   checked, want.u, want.v, want.red, want.green, want.blue, want.bad_den,
                   got.u, got.v, got.red, got.green, got.blue, got.bad_den);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  flow_e          flow = FlowFree;
  warp_scoreboard sb = new();
  int unsigned    cycles = 0;
  int             loads_sent = 0;
  int             requests_sent = 0;

  always #5 clk_i = ~clk_i;

  perspective_warp_bilinear dut (.*);

  // Run guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure and checking.
  always @(negedge clk_i) begin
    if (rst_ni)
      m_axis_tready <= (flow == FlowRecvStall) ? ($urandom_range(0, 99) >= 82) :
                       (flow == FlowBoth)      ? ($urandom_range(0, 99) >= 14) : 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result({m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tdata[31:24],
                       m_axis_tdata[39:32], m_axis_tdata[47:40], m_axis_tuser[0]});
  end

  task automatic write_coef(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_coef(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_matrix(logic [31:0] a [8]);
    write_coef(RegA0, a[0]);
    write_coef(RegA1, a[1]);
    write_coef(RegA2, a[2]);
    write_coef(RegA3, a[3]);
    write_coef(RegA4, a[4]);
    write_coef(RegA5, a[5]);
    write_coef(RegA6, a[6]);
    write_coef(RegA7, a[7]);
  endtask

  // Sends one item; valid stays high into the next item unless idling.
  task automatic send_pixel_item(pixel_item_t it);
    int idle_pct;
    idle_pct = (flow == FlowSendIdle) ? 82 : (flow == FlowBoth) ? 14 : 0;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = it.kind;
    s_axis_tdata = {it.blue, it.green, it.red, it.py, it.px};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
    if (it.kind == pwb_pkg::KindLoad) loads_sent++;
    else requests_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Waits for every expected result, then for loads still in flight.
  task automatic drain();
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);
  endtask

  function automatic pixel_item_t make_item(logic kind, int x, int y,
                                             int r, int g, int b);
    pixel_item_t it;
    it.kind = kind;
    it.px = 12'(x);
    it.py = 12'(y);
    it.red = 8'(r);
    it.green = 8'(g);
    it.blue = 8'(b);
    return it;
  endfunction

  // Mostly loads and requests near the origin, where the matrices land.
  function automatic pixel_item_t random_item();
    pixel_item_t it;
    it = make_item(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
    if ($urandom_range(0, 99) < 80) begin
      it.px = 12'($urandom_range(0, 40));
      it.py = 12'($urandom_range(0, 40));
    end
    return it;
  endfunction

  function automatic logic [31:0] signed_rand(int mag);
    int v;
    v = $urandom_range(0, mag);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  initial begin
    logic [31:0] mat [8];
    sb.clear();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      flow = flow_e'(ph);
      case (ph)
        0: mat = '{32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0};
        1: mat = '{32'd65536 + signed_rand(30000), signed_rand(20000),
                   signed_rand(1 << 20), signed_rand(20000),
                   32'd65536 + signed_rand(30000), signed_rand(1 << 20),
                   signed_rand(1 << 18), signed_rand(1 << 18)};
        // Register extremes.
        2: mat = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h80000000,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000};
        // Projective row drives the denominator through zero.
        default: mat = '{32'd40000, signed_rand(8000), signed_rand(1 << 19),
                         signed_rand(8000), 32'd40000, signed_rand(1 << 19),
                         -$urandom_range(1 << 21, 1 << 24), signed_rand(1 << 22)};
      endcase
      write_matrix(mat);

      if (ph == 0) begin
        // Loads near the corners and off the image, then edge requests.
        send_pixel_item(make_item(pwb_pkg::KindLoad, 0, 0, 255, 0, 255));
        send_pixel_item(make_item(pwb_pkg::KindLoad, 1, 0, 0, 255, 0));
        send_pixel_item(make_item(pwb_pkg::KindLoad, 0, 1, 255, 255, 255));
        send_pixel_item(make_item(pwb_pkg::KindLoad, 1, 1, 128, 64, 32));
        send_pixel_item(make_item(pwb_pkg::KindLoad, 511, 511, 255, 255, 255));
        send_pixel_item(make_item(pwb_pkg::KindLoad, 510, 511, 17, 34, 51));
        send_pixel_item(make_item(pwb_pkg::KindLoad, 511, 0, 200, 100, 50));
        send_pixel_item(make_item(pwb_pkg::KindLoad, 0, 511, 9, 8, 7));
        send_pixel_item(make_item(pwb_pkg::KindLoad, 512, 0, 1, 2, 3));
        send_pixel_item(make_item(pwb_pkg::KindLoad, 0, 512, 4, 5, 6));
        send_pixel_item(make_item(pwb_pkg::KindLoad, 4095, 4095, 255, 255, 255));
        send_pixel_item(make_item(pwb_pkg::KindRequest, 0, 0, 0, 0, 0));
        send_pixel_item(make_item(pwb_pkg::KindRequest, 509, 509, 255, 255, 255));
        send_pixel_item(make_item(pwb_pkg::KindRequest, 510, 510, 0, 0, 0));
        send_pixel_item(make_item(pwb_pkg::KindRequest, 4095, 4095, 0, 0, 0));
        send_pixel_item(make_item(pwb_pkg::KindRequest, 4095, 0, 0, 0, 0));
        send_pixel_item(make_item(pwb_pkg::KindRequest, 0, 4095, 0, 0, 0));
        send_pixel_item(make_item(pwb_pkg::KindRequest, 510, 0, 0, 0, 0));
      end
      for (int n = 0; n < RandPerPhase; n++) send_pixel_item(random_item());
      stop_sending();
      drain();
    end

    $display("Checked %0d results (%0d with bad denominator) from %0d loads and %0d requests,",
             sb.checked, sb.bad_den_seen, loads_sent, requests_sent);
    $display("over four coefficient sets and four flow-control patterns.");
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("ERROR: %0d mismatches, %0d results missing", sb.mismatches,
               sb.pending_pixels.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### files.f
rtl/pwb_pkg.sv
rtl/pwb_transform.sv
rtl/pwb_div.sv
rtl/pwb_mem.sv
rtl/pwb_blend.sv
rtl/perspective_warp_bilinear.sv
sim/perspective_warp_bilinear_tb.sv
